/* rtl/core/lvcp_pkg.sv */
// Shared types and constants of the voltage-compensated LED PWM block.
package lvcp_pkg;

  localparam int CHANNELS = 3;
  localparam int MV_W     = 13;
  localparam int REG_W    = 13;
  localparam int THR_W    = 17;
  localparam int QUOT_W   = 16;
  localparam int LEVEL_W  = 8;
  localparam int DUTY_W   = 10;
  localparam int IDX_W    = 3;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 18;
  localparam int STEP_W   = 5;

  localparam logic [MV_W-1:0]   VBAT_MIN_MV = 13'd3000;
  localparam logic [MV_W-1:0]   VBAT_MAX_MV = 13'd5400;
  localparam logic [THR_W-1:0]  Q16_ONE     = 17'h10000;
  localparam logic [DUTY_W-1:0] DUTY_FULL   = 10'd1000;
  localparam logic [8:0]        LEVEL_FULL  = 9'd255;

  localparam logic [REG_W-1:0] RED_DROP_RST   = 13'd1600;
  localparam logic [REG_W-1:0] GREEN_DROP_RST = 13'd400;
  localparam logic [REG_W-1:0] BLUE_DROP_RST  = 13'd540;
  localparam logic [REG_W-1:0] FWD_RST        = 13'd3000;

  localparam logic [IDX_W-1:0] REG_RED_DROP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GREEN_DROP = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLUE_DROP  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RED_FWD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_GREEN_FWD  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLUE_FWD   = 3'd5;

  localparam logic [3:0]        THR_LAST_STEP = 4'(QUOT_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST_STEP = 5'(MUL_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'(PROD_W - 1);

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_THR_SETUP,
    TOP_THR_WAIT,
    TOP_DUTY_RUN,
    TOP_DUTY_PUT
  } top_state_t;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_MUL,
    LANE_DIV
  } lane_state_t;

endpackage

/* rtl/core/lvcp_thr_div.sv */
// Bit-serial restoring divider for the channel throttle, one quotient bit per cycle.
module lvcp_thr_div
  import lvcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [REG_W-1:0]  drop,
  input  logic [MV_W-1:0]   den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic            busy;
  logic [3:0]      count;
  logic [MV_W-1:0] den_q;
  logic [MV_W-1:0] rem;
  logic [MV_W:0]   trial;
  logic [MV_W:0]   diff;
  logic            ge;

  assign trial = {rem, 1'b0};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 4'd1;
        if (count == THR_LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= drop;
      den_q <= den;
    end else if (busy) begin
      rem  <= ge ? diff[MV_W-1:0] : trial[MV_W-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/lvcp_duty_lane.sv */
// One duty lane: serial multiply of throttle by level times 1000, then serial divide by 255.
module lvcp_duty_lane
  import lvcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [THR_W-1:0]   throttle,
  input  logic [LEVEL_W-1:0] level,
  output logic               done,
  output logic [DUTY_W-1:0]  duty
);

  lane_state_t       state, state_next;
  logic [STEP_W-1:0] count;
  logic              mul_en, div_en, mul_last, div_last;
  logic [THR_W-1:0]  mult;
  logic [MUL_W-1:0]  mplier;
  logic [MUL_W-1:0]  m_init;
  logic [THR_W-1:0]  acc;
  logic [PROD_W-1:0] plow;
  logic [PROD_W-1:0] zsh;
  logic [THR_W:0]    sum;
  logic [THR_W-1:0]  acc_step;
  logic [PROD_W-1:0] plow_step;
  logic [7:0]        r;
  logic [8:0]        t;
  logic              ge;
  logic [8:0]        t_sub;
  logic [DUTY_W-1:0] q;

  assign m_init = {level, 10'b0} - {6'b0, level, 4'b0} - {7'b0, level, 3'b0};

  assign sum       = {1'b0, acc} + (mplier[0] ? {1'b0, mult} : '0);
  assign acc_step  = sum[THR_W:1];
  assign plow_step = {sum[0], plow[PROD_W-1:1]};

  assign t     = {r, zsh[PROD_W-1]};
  assign ge    = t >= LEVEL_FULL;
  assign t_sub = t - LEVEL_FULL;

  assign duty = (q > DUTY_FULL) ? DUTY_FULL : q;

  always_comb begin
    state_next = state;
    unique case (state)
      LANE_IDLE: if (start)    state_next = LANE_MUL;
      LANE_MUL:  if (mul_last) state_next = LANE_DIV;
      LANE_DIV:  if (div_last) state_next = LANE_IDLE;
      default:                 state_next = LANE_IDLE;
    endcase
  end

  always_comb begin
    mul_en   = 1'b0;
    div_en   = 1'b0;
    unique case (state)
      LANE_MUL: mul_en = 1'b1;
      LANE_DIV: div_en = 1'b1;
      default:  ;
    endcase
    mul_last = mul_en && (count == MUL_LAST_STEP);
    div_last = div_en && (count == DIV_LAST_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LANE_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= div_last;
      if (start || mul_last || div_last) begin
        count <= '0;
      end else if (mul_en || div_en) begin
        count <= count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mult   <= throttle;
      mplier <= m_init;
      acc    <= '0;
      r      <= '0;
    end else if (mul_en) begin
      acc    <= acc_step;
      plow   <= plow_step;
      mplier <= {1'b0, mplier[MUL_W-1:1]};
      if (mul_last) begin
        zsh <= {acc_step[15:0], plow_step[PROD_W-1:PROD_W-2]};
      end
    end else if (div_en) begin
      r   <= ge ? t_sub[7:0] : t[7:0];
      zsh <= {zsh[PROD_W-2:0], 1'b0};
      q   <= {q[DUTY_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/led_voltage_compensated_pwm.sv */
// Top level of the three-channel LED PWM duty generator with battery compensation.
//
// Item channel (item_valid, item_stall): one item per handshake. action 0 carries
// a battery voltage, clamped to 3000..5400 mV; action 1 carries three levels.
// A voltage item gives no result. When the clamped voltage is unchanged the block
// is free again in the next cycle; otherwise the shared serial divider recomputes
// the three throttles in turn, setting a channel held at unity directly and
// running its 16-step divide for any other; item_stall stays high until all three
// are written. A colour item runs three lanes side by side: a serial multiply and
// then a serial divide by 255; no new item is taken until the result has been
// loaded into the output register.
// Result channel (result_valid, result_stall): three duties and duty_changed.
// The result sits in an output register; while the receiver stalls it holds, and
// the next item is still taken and worked on, waiting only if its own result is
// ready before the earlier one has gone.
// Configuration (cfg_valid, cfg_ready): cfg_ready is always high; write only
// while the block is idle. Reset restores register defaults, the nominal battery
// voltage, unity throttles and zero last duties, and drops any pending result.
module led_voltage_compensated_pwm
  import lvcp_pkg::*;
#(
  parameter int NOMINAL_MV = 3700
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               action,
  input  logic [15:0]        millivolts,
  input  logic [LEVEL_W-1:0] red_level,
  input  logic [LEVEL_W-1:0] green_level,
  input  logic [LEVEL_W-1:0] blue_level,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [DUTY_W-1:0]  red_duty,
  output logic [DUTY_W-1:0]  green_duty,
  output logic [DUTY_W-1:0]  blue_duty,
  output logic               duty_changed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  top_state_t         state, state_next;
  logic [MV_W-1:0]    battery_mv;
  logic [MV_W-1:0]    mv_clamped;
  logic [THR_W-1:0]   throttle  [CHANNELS];
  logic [DUTY_W-1:0]  last_duty [CHANNELS];
  logic [REG_W-1:0]   drop_reg  [CHANNELS];
  logic [REG_W-1:0]   fwd_reg   [CHANNELS];
  logic [LEVEL_W-1:0] levels    [CHANNELS];
  logic [DUTY_W-1:0]  lane_duty [CHANNELS];
  logic [CHANNELS-1:0] lane_done;
  logic [1:0]         ch;
  logic [MV_W:0]      headroom;
  logic               thr_full;
  logic               accept, volt_new, color_start;
  logic               div_start, div_done, thr_write, thr_last;
  logic               out_load, changed;
  logic [QUOT_W-1:0]  div_quot;

  assign cfg_ready = 1'b1;

  assign levels[0] = red_level;
  assign levels[1] = green_level;
  assign levels[2] = blue_level;

  always_comb begin
    priority if (millivolts < 16'(VBAT_MIN_MV)) begin
      mv_clamped = VBAT_MIN_MV;
    end else if (millivolts > 16'(VBAT_MAX_MV)) begin
      mv_clamped = VBAT_MAX_MV;
    end else begin
      mv_clamped = millivolts[MV_W-1:0];
    end
  end

  assign headroom = {1'b0, battery_mv} - {1'b0, fwd_reg[ch]};
  assign thr_full = headroom[MV_W] || ({1'b0, drop_reg[ch]} >= headroom);
  assign thr_last = ch == 2'(CHANNELS - 1);

  assign changed = (lane_duty[0] != last_duty[0]) || (lane_duty[1] != last_duty[1])
                || (lane_duty[2] != last_duty[2]);

  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    thr_write  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      TOP_IDLE:      item_stall = 1'b0;
      TOP_THR_SETUP: begin
        div_start = !thr_full;
        thr_write = thr_full;
      end
      TOP_THR_WAIT:  thr_write = div_done;
      TOP_DUTY_PUT:  out_load = !result_valid || !result_stall;
      default:       ;
    endcase
    accept      = item_valid && !item_stall;
    volt_new    = accept && !action && (mv_clamped != battery_mv);
    color_start = accept && action;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE: begin
        if (volt_new) begin
          state_next = TOP_THR_SETUP;
        end else if (color_start) begin
          state_next = TOP_DUTY_RUN;
        end
      end
      TOP_THR_SETUP: begin
        if (!thr_full) begin
          state_next = TOP_THR_WAIT;
        end else if (thr_last) begin
          state_next = TOP_IDLE;
        end
      end
      TOP_THR_WAIT: begin
        if (div_done) begin
          state_next = thr_last ? TOP_IDLE : TOP_THR_SETUP;
        end
      end
      TOP_DUTY_RUN: if (&lane_done) state_next = TOP_DUTY_PUT;
      TOP_DUTY_PUT: if (out_load)   state_next = TOP_IDLE;
      default:                      state_next = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_reg[0] <= RED_DROP_RST;
      drop_reg[1] <= GREEN_DROP_RST;
      drop_reg[2] <= BLUE_DROP_RST;
      fwd_reg[0]  <= FWD_RST;
      fwd_reg[1]  <= FWD_RST;
      fwd_reg[2]  <= FWD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED_DROP:   drop_reg[0] <= cfg_data;
        REG_GREEN_DROP: drop_reg[1] <= cfg_data;
        REG_BLUE_DROP:  drop_reg[2] <= cfg_data;
        REG_RED_FWD:    fwd_reg[0]  <= cfg_data;
        REG_GREEN_FWD:  fwd_reg[1]  <= cfg_data;
        REG_BLUE_FWD:   fwd_reg[2]  <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= TOP_IDLE;
      battery_mv   <= MV_W'(NOMINAL_MV);
      ch           <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        throttle[i]  <= Q16_ONE;
        last_duty[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (volt_new) begin
        battery_mv <= mv_clamped;
        ch         <= '0;
      end else if (thr_write && !thr_last) begin
        ch <= ch + 2'd1;
      end
      if (thr_write) begin
        throttle[ch] <= (state == TOP_THR_SETUP) ? Q16_ONE : {1'b0, div_quot};
      end
      if (out_load) begin
        result_valid <= 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          last_duty[i] <= lane_duty[i];
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_duty     <= lane_duty[0];
      green_duty   <= lane_duty[1];
      blue_duty    <= lane_duty[2];
      duty_changed <= changed;
    end
  end

  lvcp_thr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .drop  (drop_reg[ch]),
    .den   (headroom[MV_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lvcp_duty_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (color_start),
      .throttle (throttle[i]),
      .level    (levels[i]),
      .done     (lane_done[i]),
      .duty     (lane_duty[i])
    );
  end

endmodule

/* rtl/core/lvcp_checker.sv */
// Port-level checks of the LED PWM block, bound to the top level.
module lvcp_checker
  import lvcp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               action,
  input logic               result_valid,
  input logic               result_stall,
  input logic [DUTY_W-1:0]  red_duty,
  input logic [DUTY_W-1:0]  green_duty,
  input logic [DUTY_W-1:0]  blue_duty,
  input logic               duty_changed
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(red_duty)
      && $stable(green_duty) && $stable(blue_duty) && $stable(duty_changed))
    else $error("stalled result changed");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> red_duty <= DUTY_FULL && green_duty <= DUTY_FULL
      && blue_duty <= DUTY_FULL)
    else $error("duty above full scale");

  a_voltage_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !action && !result_valid |=> !result_valid)
    else $error("voltage item produced a result");

endmodule

bind led_voltage_compensated_pwm lvcp_checker u_lvcp_checker (.*);
